### hdl/sobel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int CfgW = 12;
	localparam logic [CfgW-1:0] WidthReset  = 12'd640;
	localparam logic [CfgW-1:0] HeightReset = 12'd480;
	localparam logic [7:0] MagSat = 8'd255;

	localparam int OutDepth = 4;
	localparam int OutPtrW  = $clog2(OutDepth);
	localparam int OutLvlW  = OutPtrW + 1;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] older;
		logic [7:0] newer;
	} line_pair_t;

	typedef struct packed {
		logic [7:0]  edge_magnitude;
		logic [11:0] center_row;
		logic [10:0] center_col;
		logic        frame_last;
	} result_t;

endpackage
`default_nettype wire

### hdl/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel filter on a raster stream of grey pixels, |gx|+|gy| saturated
// at 255, one result per interior pixel.
// ----------------------------------------------------------------------------
// One pixel is taken every clock while in_stall is low. The two previous
// lines live in a single line memory of MAX_LINE_WIDTH entries (16 bits
// wide, one read and one write each cycle); a pixel reads its column at
// acceptance and writes it back in the next cycle, and a bypass covers the
// one-pixel-wide frame. Results pass both pipeline stages into a four-entry
// output queue; input stall rises when queue level plus valid stage entries
// reach the queue depth. Border pixels give no result, and frame_last marks
// the last interior pixel of a frame. The line memory needs no clearing
// after reset. The user must write width and height only while the block
// is idle; the block does not enforce it. A width above MAX_LINE_WIDTH
// counts as MAX_LINE_WIDTH and a zero width or height counts as one.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int MAX_LINE_WIDTH = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  sobel_pkg::cfg_reg_t                 cfg_index,
	input  wire logic [sobel_pkg::CfgW-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     grey_pixel,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          edge_magnitude,
	output logic [11:0]                         center_row,
	output logic [10:0]                         center_col,
	output logic                                frame_last
);
	import sobel_pkg::*;

	localparam int ColW = $clog2(MAX_LINE_WIDTH);
	localparam int CmpW = ((ColW > CfgW) ? ColW : CfgW) + 1;

	function automatic logic signed [10:0] px(input logic [7:0] v);
		px = signed'({3'b000, v});
	endfunction

	// configuration
	logic [CfgW-1:0] width_q;
	logic [CfgW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters
	logic [ColW-1:0]  col_q;
	logic [11:0]      row_q;
	logic             in_xfer;
	logic [CmpW-1:0]  w_raw;
	logic [CmpW-1:0]  w_eff;
	logic [CmpW-1:0]  col_inc;
	logic [CmpW-1:0]  col_dec;
	logic [12:0]      row_inc;
	logic [12:0]      h_eff;
	logic             col_wrap;
	logic             row_wrap;
	logic             produce;

	assign in_xfer  = in_valid && !in_stall;
	assign w_raw    = (width_q == '0) ? CmpW'(1) : CmpW'(width_q);
	assign w_eff    = (w_raw > CmpW'(MAX_LINE_WIDTH)) ? CmpW'(MAX_LINE_WIDTH) : w_raw;
	assign col_inc  = CmpW'(col_q) + CmpW'(1);
	assign col_dec  = CmpW'(col_q) - CmpW'(1);
	assign row_inc  = {1'b0, row_q} + 13'd1;
	assign h_eff    = (height_q == '0) ? 13'd1 : {1'b0, height_q};
	assign col_wrap = (col_inc >= w_eff);
	assign row_wrap = (row_inc >= h_eff);
	assign produce  = (row_q >= 12'd2) && (CmpW'(col_q) >= CmpW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? 12'd0 : row_inc[11:0];
			end else begin
				col_q <= col_inc[ColW-1:0];
			end
		end
	end

	// stage 1: line memory data, window and gradients
	logic             s1_v;
	logic [7:0]       s1_pix;
	logic [ColW-1:0]  s1_col;
	logic             s1_prod;
	logic [11:0]      s1_row_c;
	logic [10:0]      s1_col_c;
	logic             s1_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1_pix   <= grey_pixel;
			s1_col   <= col_q;
			s1_prod  <= produce;
			s1_row_c <= row_q - 12'd1;
			s1_col_c <= col_dec[10:0];
			s1_last  <= produce && col_wrap && row_wrap;
		end
	end

	line_pair_t rd_pair;
	line_pair_t wr_pair;
	logic [7:0] top;
	logic [7:0] mid;

	assign top = rd_pair.older;
	assign mid = rd_pair.newer;
	assign wr_pair = '{older: mid, newer: s1_pix};

	sobel_line_store #(
		.DEPTH(MAX_LINE_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (rd_pair),
		.wr_en   (s1_v),
		.wr_addr (s1_col),
		.wr_data (wr_pair)
	);

	logic [7:0] w00_q, w01_q, w10_q, w11_q, w20_q, w21_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w00_q <= '0;
			w01_q <= '0;
			w10_q <= '0;
			w11_q <= '0;
			w20_q <= '0;
			w21_q <= '0;
		end else if (s1_v) begin
			w00_q <= w01_q;
			w01_q <= top;
			w10_q <= w11_q;
			w11_q <= mid;
			w20_q <= w21_q;
			w21_q <= s1_pix;
		end
	end

	logic signed [10:0] gx;
	logic signed [10:0] gy;

	assign gx = px(w00_q) - px(top) + (px(w10_q) <<< 1) - (px(mid) <<< 1)
		+ px(w20_q) - px(s1_pix);
	assign gy = px(w00_q) + (px(w01_q) <<< 1) + px(top) - px(w20_q)
		- (px(w21_q) <<< 1) - px(s1_pix);

	// stage 2: magnitude and saturation
	logic               s2_v;
	logic signed [10:0] s2_gx;
	logic signed [10:0] s2_gy;
	logic [11:0]        s2_row_c;
	logic [10:0]        s2_col_c;
	logic               s2_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= s1_v && s1_prod;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v) begin
			s2_gx    <= gx;
			s2_gy    <= gy;
			s2_row_c <= s1_row_c;
			s2_col_c <= s1_col_c;
			s2_last  <= s1_last;
		end
	end

	logic signed [10:0] ngx;
	logic signed [10:0] ngy;
	logic [9:0]         ax;
	logic [9:0]         ay;
	logic [10:0]        mag_sum;
	result_t            s2_res;

	assign ngx     = -s2_gx;
	assign ngy     = -s2_gy;
	assign ax      = s2_gx[10] ? ngx[9:0] : s2_gx[9:0];
	assign ay      = s2_gy[10] ? ngy[9:0] : s2_gy[9:0];
	assign mag_sum = {1'b0, ax} + {1'b0, ay};

	assign s2_res.edge_magnitude = (mag_sum > 11'(MagSat)) ? MagSat : mag_sum[7:0];
	assign s2_res.center_row     = s2_row_c;
	assign s2_res.center_col     = s2_col_c;
	assign s2_res.frame_last     = s2_last;

	// result queue
	result_t             out_res;
	logic [OutLvlW-1:0]  fifo_level;
	logic [OutLvlW:0]    occupancy;

	sobel_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s2_v),
		.push_data (s2_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res),
		.level     (fifo_level)
	);

	assign occupancy = {1'b0, fifo_level} + (OutLvlW+1)'(s1_v) + (OutLvlW+1)'(s2_v);
	assign in_stall  = (occupancy >= (OutLvlW+1)'(OutDepth));

	assign edge_magnitude = out_res.edge_magnitude;
	assign center_row     = out_res.center_row;
	assign center_col     = out_res.center_col;
	assign frame_last     = out_res.frame_last;

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(s2_v && (fifo_level == OutLvlW'(OutDepth))))
		else $error("result queue overflow");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_level <= OutLvlW'(OutDepth))
		else $error("result queue level out of range");

	a_last_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && produce && col_wrap && row_wrap |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after last interior pixel");

endmodule
`default_nettype wire

### hdl/sobel_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_line_store
// Two line buffers in one memory, one read and one write per cycle, with
// bypass of a write to the entry being read at the same edge.
// ----------------------------------------------------------------------------
module sobel_line_store #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output sobel_pkg::line_pair_t      rd_data,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  sobel_pkg::line_pair_t      wr_data
);
	import sobel_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t ram_q;
	line_pair_t fwd_q;
	logic       fwd_sel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_sel_q <= 1'b0;
		end else if (rd_en) begin
			fwd_sel_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_sel_q ? fwd_q : ram_q;

endmodule
`default_nettype wire

### hdl/sobel_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_out_fifo
// Small result queue that decouples the filter pipeline from output stall.
// ----------------------------------------------------------------------------
module sobel_out_fifo (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  sobel_pkg::result_t                    push_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output sobel_pkg::result_t                    out_data,
	output logic [sobel_pkg::OutLvlW-1:0]         level
);
	import sobel_pkg::*;

	result_t            mem [OutDepth];
	logic [OutPtrW-1:0] wr_ptr_q;
	logic [OutPtrW-1:0] rd_ptr_q;
	logic [OutLvlW-1:0] cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem[rd_ptr_q];
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire
